### rtl/bspq_pkg.sv
// ----------------------------------------------------------------------------
// bspq_pkg: shared types and constants of the bounded stable priority queue
// Holds the queue depth, the derived widths, the operation codes, the
// sequencer states and the packed beat types of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package bspq_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_POP_CAP,
        S_POP_RD,
        S_POP_WR,
        S_PEEK_CAP,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] data_in;
        logic [7:0]         priority_in;
    } t_in_beat;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] data_out;
        logic               is_empty;
        logic [4:0]         occupancy;
    } t_out_beat;

    typedef struct packed {
        logic signed [31:0] data;
        logic [7:0]         prio;
    } t_slot;

endpackage

`default_nettype wire

### rtl/bounded_stable_priority_queue.sv
// ----------------------------------------------------------------------------
// bounded_stable_priority_queue: sorted priority queue with stable ties
// Keeps up to DEPTH words in a slot memory sorted by priority, highest at
// slot 0, equal priorities in arrival order. One sequencer drives a single
// read port, a single write port and one priority comparator.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------
//   input   | in        | i_valid / o_ready | i_in  (op, data_in, priority_in)
//   result  | out       | o_valid / i_ready | o_out (ok, data_out, is_empty,
//           |           |                   |        occupancy)
//
// One beat is taken at a time. A push moves each entry whose priority is
// below the new one a slot toward the tail, with a read and a compare state
// per entry, and writes the new entry into the slot left free. A pop
// captures the head, then moves each of the n entries left behind it up one
// slot with a read and a write state per entry. A peek captures the head;
// a failing or unknown operation goes straight to its result. The one memory
// read port sets these sequences. Each result then waits in its output
// register until i_ready takes it; a new input beat is taken only after that.
// Reset empties the queue at once; the slot memory needs no clearing pass,
// since only slots below the fill count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stable_priority_queue
    import bspq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_beat  i_in,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_beat      o_out
);

    // Slot memory: one write and one registered read per cycle.
    t_slot mem [DEPTH];

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_fill,  n_fill;
    logic [CNT_W-1:0] r_idx,   n_idx;
    t_in_beat         r_cmd,   n_cmd;
    t_out_beat        r_out,   n_out;
    t_slot            r_rd;

    logic             in_acc;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    t_slot            wr_data;
    logic [AW-1:0]    rd_addr;
    logic [CNT_W-1:0] idx_m1;
    logic             shift_down;
    logic             push_full;
    logic             head_empty;
    t_slot            new_slot;

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_RESP);
    assign o_out      = r_out;
    assign in_acc     = i_valid && o_ready;
    assign idx_m1     = r_idx - 1'b1;
    assign push_full  = (r_fill == CNT_W'(DEPTH));
    assign head_empty = (r_fill == '0);
    assign new_slot   = '{data: r_cmd.data_in, prio: r_cmd.priority_in};

    // The shared comparator: an entry strictly below the new priority must
    // move one slot toward the tail; anything at or above it stays ahead.
    assign shift_down = (r_rd.prio < r_cmd.priority_in);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.op == OP_PUSH && !push_full) begin
                        n_state = S_PUSH_RD;
                    end else if (i_in.op == OP_POP && !head_empty) begin
                        n_state = S_POP_CAP;
                    end else if (i_in.op == OP_PEEK && !head_empty) begin
                        n_state = S_PEEK_CAP;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_PUSH_RD:  n_state = (r_idx == '0) ? S_RESP : S_PUSH_CMP;
            S_PUSH_CMP: n_state = shift_down ? S_PUSH_RD : S_RESP;
            S_POP_CAP:  n_state = S_POP_RD;
            S_POP_RD:   n_state = (r_idx >= r_fill) ? S_RESP : S_POP_WR;
            S_POP_WR:   n_state = S_POP_RD;
            S_PEEK_CAP: n_state = S_RESP;
            S_RESP:     n_state = i_ready ? S_IDLE : S_RESP;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_fill  = r_fill;
        n_idx   = r_idx;
        n_cmd   = r_cmd;
        n_out   = r_out;
        wr_en   = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = new_slot;
        // Slot 0 is read by default, so the head is ready right after accept.
        rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd = i_in;
                    n_idx = r_fill;
                    n_out = '{ok: 1'b0, data_out: '0, is_empty: head_empty,
                              occupancy: 5'(r_fill)};
                end
            end
            S_PUSH_RD: begin
                if (r_idx == '0) begin
                    wr_en  = 1'b1;
                    n_fill = r_fill + 1'b1;
                    n_out  = '{ok: 1'b1, data_out: '0, is_empty: 1'b0,
                               occupancy: 5'(n_fill)};
                end else begin
                    rd_addr = idx_m1[AW-1:0];
                end
            end
            S_PUSH_CMP: begin
                wr_en = 1'b1;
                if (shift_down) begin
                    wr_data = r_rd;
                    n_idx   = idx_m1;
                end else begin
                    n_fill = r_fill + 1'b1;
                    n_out  = '{ok: 1'b1, data_out: '0, is_empty: 1'b0,
                               occupancy: 5'(n_fill)};
                end
            end
            S_POP_CAP: begin
                n_out.data_out = r_rd.data;
                n_idx          = CNT_W'(1);
            end
            S_POP_RD: begin
                if (r_idx >= r_fill) begin
                    n_fill = r_fill - 1'b1;
                    n_out  = '{ok: 1'b1, data_out: r_out.data_out,
                               is_empty: (n_fill == '0),
                               occupancy: 5'(n_fill)};
                end else begin
                    rd_addr = r_idx[AW-1:0];
                end
            end
            S_POP_WR: begin
                wr_en   = 1'b1;
                wr_addr = idx_m1[AW-1:0];
                wr_data = r_rd;
                n_idx   = r_idx + 1'b1;
            end
            S_PEEK_CAP: begin
                n_out = '{ok: 1'b1, data_out: r_rd.data, is_empty: 1'b0,
                          occupancy: 5'(r_fill)};
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    // The fill count never passes the depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // The slot memory is written only while a push or a pop is at work.
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_PUSH_RD || r_state == S_PUSH_CMP ||
                   r_state == S_POP_WR))
        else $error("slot write outside push or pop");

    // A result beat reports empty exactly when its count is zero.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.is_empty == (o_out.occupancy == 5'd0)))
        else $error("empty flag disagrees with occupancy");

    // The fill count changes only on the cycle a push or pop completes.
    a_fill_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP || r_state == S_IDLE) |=> $stable(r_fill) ||
            $past(r_state) == S_IDLE)
        else $error("fill count moved while no operation was at work");

endmodule

`default_nettype wire
